>>> sv/vvm_pkg.sv
// ----------------------------------------------------------------------------
// vvm_pkg
// Types, sizes and codes shared by the VLAN/VNI map block.
// ----------------------------------------------------------------------------
package vvm_pkg;

  localparam int VLAN_ENTRIES = 4096;
  localparam int VLAN_W       = $clog2(VLAN_ENTRIES);
  localparam int IDX_W        = VLAN_W + 1;

  localparam int KIND_W = 3;
  localparam int VLAN_ID_W = 12;
  localparam int VNI_W = 24;
  localparam int CNT_W = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD         = 3'd0,
    KIND_REM_VLAN    = 3'd1,
    KIND_REM_VNI     = 3'd2,
    KIND_LOOKUP_VLAN = 3'd3,
    KIND_LOOKUP_VNI  = 3'd4,
    KIND_CLEAR       = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } st_e;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [VLAN_ID_W-1:0] vlan_id;
    logic [VNI_W-1:0]     vni_key;
  } req_t;

  typedef struct packed {
    logic [VNI_W-1:0]     vni_answer;
    logic [VLAN_ID_W-1:0] vlan_answer;
    logic                 success;
    logic [CNT_W-1:0]     mapping_total;
  } rsp_t;

  typedef struct packed {
    logic [VNI_W-1:0]     vni_answer;
    logic [VLAN_ID_W-1:0] vlan_answer;
    logic                 success;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [VNI_W-1:0] vni;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [VLAN_W-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic inc;
    logic dec;
    logic clr;
  } cnt_cmd_t;

endpackage

>>> sv/vvm_req_if.sv
// ----------------------------------------------------------------------------
// vvm_req_if
// Request channel: valid/ready handshake carrying one map operation.
// ----------------------------------------------------------------------------
interface vvm_req_if;
  logic          valid;
  logic          ready;
  vvm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/vvm_rsp_if.sv
// ----------------------------------------------------------------------------
// vvm_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface vvm_rsp_if;
  logic          valid;
  logic          ready;
  vvm_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/vvm_ram.sv
// ----------------------------------------------------------------------------
// vvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/vvm_ctrl.sv
// ----------------------------------------------------------------------------
// vvm_ctrl
// Sequencer for the map: clear sweep, direct VLAN access, and a pipelined
// VNI scan through one shared entry comparator.
// ----------------------------------------------------------------------------
module vvm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  vvm_pkg::req_t                req_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output vvm_pkg::res_t                res_o,
  output vvm_pkg::cnt_cmd_t            cnt_o,
  output vvm_pkg::ram_wr_t             wr_o,
  output logic [vvm_pkg::VLAN_W-1:0]   raddr_o,
  input  vvm_pkg::entry_t              rdata_i
);

  localparam logic [vvm_pkg::IDX_W-1:0] IdxEnd  = vvm_pkg::IDX_W'(vvm_pkg::VLAN_ENTRIES);
  localparam logic [vvm_pkg::IDX_W-1:0] IdxLast = vvm_pkg::IDX_W'(vvm_pkg::VLAN_ENTRIES - 1);

  vvm_pkg::st_e                 state_q, state_d;
  vvm_pkg::req_t                req_q, req_d;
  vvm_pkg::res_t                res_q, res_d;
  logic [vvm_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [vvm_pkg::VLAN_W-1:0]   chk_idx_q, chk_idx_d;
  logic                         chk_vld_q, chk_vld_d;
  logic                         sweep_q, sweep_d;
  logic                         in_tab;
  logic                         match;

  assign in_tab = {1'b0, req_i.vlan_id} < (vvm_pkg::VLAN_ID_W + 1)'(vvm_pkg::VLAN_ENTRIES);
  assign match  = chk_vld_q && rdata_i.valid && (rdata_i.vni == req_q.vni_key);
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vvm_pkg::ST_CLEAR;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      sweep_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      sweep_q   <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    chk_idx_q <= chk_idx_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    idx_d       = idx_q;
    chk_idx_d   = idx_q[vvm_pkg::VLAN_W-1:0];
    chk_vld_d   = 1'b0;
    sweep_d     = sweep_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    cnt_o       = '0;
    wr_o.we     = 1'b0;
    wr_o.addr   = req_q.vlan_id[vvm_pkg::VLAN_W-1:0];
    wr_o.data   = '0;
    raddr_o     = req_q.vlan_id[vvm_pkg::VLAN_W-1:0];

    case (state_q)
      vvm_pkg::ST_CLEAR: begin
        wr_o.we   = 1'b1;
        wr_o.addr = idx_q[vvm_pkg::VLAN_W-1:0];
        if (idx_q == IdxLast) begin
          idx_d = '0;
          if (sweep_q) begin
            sweep_d       = 1'b0;
            cnt_o.clr     = 1'b1;
            res_d.success = 1'b1;
            state_d       = vvm_pkg::ST_RESP;
          end else begin
            state_d = vvm_pkg::ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      vvm_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          idx_d = '0;
          case (req_i.kind)
            vvm_pkg::KIND_ADD, vvm_pkg::KIND_REM_VLAN: begin
              state_d = in_tab ? vvm_pkg::ST_RD : vvm_pkg::ST_RESP;
            end
            vvm_pkg::KIND_LOOKUP_VLAN: begin
              res_d.success = !in_tab;
              state_d       = in_tab ? vvm_pkg::ST_RD : vvm_pkg::ST_RESP;
            end
            vvm_pkg::KIND_REM_VNI: begin
              state_d = vvm_pkg::ST_SCAN;
            end
            vvm_pkg::KIND_LOOKUP_VNI: begin
              if (req_i.vni_key == '0) begin
                res_d.success = 1'b1;
                state_d       = vvm_pkg::ST_RESP;
              end else begin
                state_d = vvm_pkg::ST_SCAN;
              end
            end
            vvm_pkg::KIND_CLEAR: begin
              sweep_d = 1'b1;
              state_d = vvm_pkg::ST_CLEAR;
            end
            default: begin
              state_d = vvm_pkg::ST_RESP;
            end
          endcase
        end
      end

      vvm_pkg::ST_RD: begin
        state_d = vvm_pkg::ST_CHK;
      end

      vvm_pkg::ST_CHK: begin
        state_d = vvm_pkg::ST_RESP;
        case (req_q.kind)
          vvm_pkg::KIND_ADD: begin
            if (rdata_i.valid) begin
              wr_o.we   = 1'b1;
              cnt_o.dec = 1'b1;
            end
            state_d = vvm_pkg::ST_SCAN;
          end
          vvm_pkg::KIND_REM_VLAN: begin
            if (rdata_i.valid) begin
              wr_o.we       = 1'b1;
              cnt_o.dec     = 1'b1;
              res_d.success = 1'b1;
            end
          end
          vvm_pkg::KIND_LOOKUP_VLAN: begin
            res_d.success    = 1'b1;
            res_d.vni_answer = rdata_i.valid ? rdata_i.vni : '0;
          end
          default: begin
          end
        endcase
      end

      vvm_pkg::ST_SCAN: begin
        raddr_o = idx_q[vvm_pkg::VLAN_W-1:0];
        if (match) begin
          state_d = vvm_pkg::ST_RESP;
          case (req_q.kind)
            vvm_pkg::KIND_ADD: begin
              wr_o.we   = 1'b1;
              wr_o.addr = chk_idx_q;
              cnt_o.dec = 1'b1;
              state_d   = vvm_pkg::ST_WRITE;
            end
            vvm_pkg::KIND_REM_VNI: begin
              wr_o.we       = 1'b1;
              wr_o.addr     = chk_idx_q;
              cnt_o.dec     = 1'b1;
              res_d.success = 1'b1;
            end
            vvm_pkg::KIND_LOOKUP_VNI: begin
              res_d.success     = 1'b1;
              res_d.vlan_answer = vvm_pkg::VLAN_ID_W'(chk_idx_q);
            end
            default: begin
            end
          endcase
        end else if ((idx_q == IdxEnd) && !chk_vld_q) begin
          state_d = vvm_pkg::ST_RESP;
          case (req_q.kind)
            vvm_pkg::KIND_ADD: begin
              state_d = vvm_pkg::ST_WRITE;
            end
            vvm_pkg::KIND_LOOKUP_VNI: begin
              res_d.success = 1'b1;
            end
            default: begin
            end
          endcase
        end else if (idx_q != IdxEnd) begin
          idx_d     = idx_q + 1'b1;
          chk_vld_d = 1'b1;
        end
      end

      vvm_pkg::ST_WRITE: begin
        wr_o.we        = 1'b1;
        wr_o.data.valid = 1'b1;
        wr_o.data.vni  = req_q.vni_key;
        cnt_o.inc      = 1'b1;
        res_d.success  = 1'b1;
        state_d        = vvm_pkg::ST_RESP;
      end

      vvm_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = vvm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = vvm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/vlan_vni_bidirectional_map.sv
// ----------------------------------------------------------------------------
// vlan_vni_bidirectional_map
// One-to-one VLAN/VNI map held in a VLAN-indexed RAM, with a mapping count.
//
//   channel  dir  handshake         payload
//   req_i    in   valid/ready       kind, vlan_id, vni_key
//   rsp_o    out  valid/ready       vni_answer, vlan_answer, success,
//                                   mapping_total
//
// VLAN-keyed removals and lookups read the VLAN's entry before their result;
// unused kinds and a lookup of VNI zero go straight to the result.
// VNI-keyed operations scan the RAM one entry per cycle through its single
// read port; an add also reads its VLAN first
// and writes the new pair last.
// Clear-all sweeps the RAM write port over every entry.
// After reset the same sweep runs with req_i not ready.
// The result register holds a finished result while rsp_o stalls.
// ----------------------------------------------------------------------------
module vlan_vni_bidirectional_map (
  input  logic       clk_i,
  input  logic       rst_ni,
  vvm_req_if.sink    req_i,
  vvm_rsp_if.source  rsp_o
);

  vvm_pkg::res_t                res;
  logic                         res_valid;
  logic                         out_free;
  vvm_pkg::cnt_cmd_t            cnt_cmd;
  vvm_pkg::ram_wr_t             wr;
  logic [vvm_pkg::VLAN_W-1:0]   raddr;
  vvm_pkg::entry_t              rdata;
  logic [vvm_pkg::CNT_W-1:0]    count_q, count_d;
  logic                         rsp_valid_q;
  vvm_pkg::rsp_t                rsp_q;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  vvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.data),
    .res_valid_o (res_valid),
    .res_ready_i (out_free),
    .res_o       (res),
    .cnt_o       (cnt_cmd),
    .wr_o        (wr),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  vvm_ram #(
    .WIDTH ($bits(vvm_pkg::entry_t)),
    .DEPTH (vvm_pkg::VLAN_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cnt_cmd.clr) begin
      count_d = '0;
    end else if (cnt_cmd.inc) begin
      count_d = count_q + 1'b1;
    end else if (cnt_cmd.dec && (count_q != '0)) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (out_free) begin
        rsp_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      rsp_q.vni_answer    <= res.vni_answer;
      rsp_q.vlan_answer   <= res.vlan_answer;
      rsp_q.success       <= res.success;
      rsp_q.mapping_total <= count_q;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vvm_pkg::CNT_W'(vvm_pkg::VLAN_ENTRIES))
    else $error("mapping count above table size");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> !req_i.ready)
    else $error("RAM written while accepting requests");

  a_count_inc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_cmd.inc && !cnt_cmd.clr |=> count_q == $past(count_q) + 1'b1)
    else $error("mapping count did not advance on add");

  a_result_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && out_free |=> rsp_valid_q && (rsp_q.mapping_total == $past(count_q)))
    else $error("result not loaded with current count");

endmodule

>>> tb/vvm_map_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vvm_map_checker
// Watches both channels of the VLAN/VNI map. Each request transfer is applied
// to a private copy of the map, and the predicted result is queued. Each
// result transfer is checked field by field against the oldest queued one.
// Reports the failure count and the number of results still outstanding.
// ----------------------------------------------------------------------------
module vvm_map_checker
  import vvm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  vvm_req_if   req_i,
  vvm_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic [VNI_W-1:0] vni_of_vlan [VLAN_ENTRIES];
  bit               vlan_held   [VLAN_ENTRIES];
  logic [CNT_W-1:0] pair_count;
  rsp_t             expected_rsp_q [$];

  function automatic int find_vlan_of_vni(logic [VNI_W-1:0] vni);
    for (int i = 0; i < VLAN_ENTRIES; i++) begin
      if (vlan_held[i] && vni_of_vlan[i] == vni) return i;
    end
    return VLAN_ENTRIES;
  endfunction

  function automatic void drop_pair(int idx);
    vlan_held[idx] = 1'b0;
    if (pair_count != '0) pair_count = pair_count - 1'b1;
  endfunction

  function automatic rsp_t apply_map_op(req_t op);
    rsp_t r;
    int   idx;
    bit   in_table;
    r        = '0;
    in_table = int'(op.vlan_id) < VLAN_ENTRIES;
    case (op.kind)
      KIND_ADD: begin
        if (in_table) begin
          if (vlan_held[op.vlan_id]) drop_pair(int'(op.vlan_id));
          idx = find_vlan_of_vni(op.vni_key);
          if (idx < VLAN_ENTRIES) drop_pair(idx);
          vni_of_vlan[op.vlan_id] = op.vni_key;
          vlan_held[op.vlan_id]   = 1'b1;
          pair_count              = pair_count + 1'b1;
          r.success               = 1'b1;
        end
      end
      KIND_REM_VLAN: begin
        if (in_table && vlan_held[op.vlan_id]) begin
          drop_pair(int'(op.vlan_id));
          r.success = 1'b1;
        end
      end
      KIND_REM_VNI: begin
        idx = find_vlan_of_vni(op.vni_key);
        if (idx < VLAN_ENTRIES) begin
          drop_pair(idx);
          r.success = 1'b1;
        end
      end
      KIND_LOOKUP_VLAN: begin
        if (in_table && vlan_held[op.vlan_id]) r.vni_answer = vni_of_vlan[op.vlan_id];
        r.success = 1'b1;
      end
      KIND_LOOKUP_VNI: begin
        if (op.vni_key != '0) begin
          idx = find_vlan_of_vni(op.vni_key);
          if (idx < VLAN_ENTRIES) r.vlan_answer = VLAN_ID_W'(idx);
        end
        r.success = 1'b1;
      end
      KIND_CLEAR: begin
        foreach (vlan_held[i]) vlan_held[i] = 1'b0;
        pair_count = '0;
        r.success  = 1'b1;
      end
      default: begin
      end
    endcase
    r.mapping_total = pair_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    rsp_t got_rsp;
    if (!rst_ni) begin
      foreach (vlan_held[i]) vlan_held[i] = 1'b0;
      pair_count = '0;
      expected_rsp_q.delete();
      fail_count_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) expected_rsp_q.push_back(apply_map_op(req_i.data));
      if (rsp_i.valid && rsp_i.ready) begin
        got_rsp = rsp_i.data;
        if (expected_rsp_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result vni=%h vlan=%h ok=%b total=%0d", $realtime,
                     got_rsp.vni_answer, got_rsp.vlan_answer, got_rsp.success,
                     got_rsp.mapping_total);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (got_rsp.vni_answer !== exp_rsp.vni_answer ||
              got_rsp.vlan_answer !== exp_rsp.vlan_answer ||
              got_rsp.success !== exp_rsp.success ||
              got_rsp.mapping_total !== exp_rsp.mapping_total) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch exp %h/%h/%b/%0d got %h/%h/%b/%0d",
                       $realtime, exp_rsp.vni_answer, exp_rsp.vlan_answer, exp_rsp.success,
                       exp_rsp.mapping_total, got_rsp.vni_answer, got_rsp.vlan_answer,
                       got_rsp.success, got_rsp.mapping_total);
          end
        end
      end
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives map operations into vlan_vni_bidirectional_map: a directed run over
// empty lookups, zero keys, key takeover on add, removals of absent keys,
// unused kinds and clear-all, then random operations over small key pools so
// that adds, removals and lookups collide. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import vvm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int POOL_N = 12;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   quiet;

  logic [VLAN_ID_W-1:0] vlan_pool [POOL_N];
  logic [VNI_W-1:0]     vni_pool  [POOL_N];

  vvm_req_if req_ch ();
  vvm_rsp_if rsp_ch ();

  always #6 clk = ~clk;

  vlan_vni_bidirectional_map uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  vvm_map_checker map_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [VLAN_ID_W-1:0] vlan,
                          input logic [VNI_W-1:0] vni);
    req_t op;
    op.kind    = kind;
    op.vlan_id = vlan;
    op.vni_key = vni;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= op;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  function automatic logic [VLAN_ID_W-1:0] pick_vlan();
    if ($urandom_range(0, 3) == 0) return VLAN_ID_W'($urandom);
    return vlan_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic logic [VNI_W-1:0] pick_vni();
    if ($urandom_range(0, 3) == 0) return VNI_W'($urandom);
    return vni_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  // receiver: random stall bursts, none once quiet
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left   = $urandom_range(0, 3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int                pick;
    logic [KIND_W-1:0] kind;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rst_n        = 1'b0;
    quiet        = 1'b0;
    foreach (vlan_pool[i]) vlan_pool[i] = VLAN_ID_W'($urandom);
    foreach (vni_pool[i]) vni_pool[i] = VNI_W'($urandom);
    vlan_pool[0] = '0;
    vlan_pool[1] = '1;
    vni_pool[0]  = '0;
    vni_pool[1]  = '1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    issue_op(KIND_LOOKUP_VLAN, 12'h000, 24'h000000);
    issue_op(KIND_LOOKUP_VNI, 12'h000, 24'h000000);
    issue_op(KIND_LOOKUP_VNI, 12'hfff, 24'hffffff);
    issue_op(KIND_REM_VLAN, 12'h005, 24'h000000);
    issue_op(KIND_REM_VNI, 12'h000, 24'h000000);
    issue_op(KIND_ADD, 12'h000, 24'h000000);
    issue_op(KIND_LOOKUP_VNI, 12'h000, 24'h000000);
    issue_op(KIND_REM_VNI, 12'hfff, 24'h000000);
    issue_op(KIND_ADD, 12'hfff, 24'hffffff);
    issue_op(KIND_LOOKUP_VLAN, 12'hfff, 24'h000000);
    issue_op(KIND_LOOKUP_VNI, 12'h000, 24'hffffff);
    issue_op(KIND_ADD, 12'h000, 24'h123456);
    issue_op(KIND_LOOKUP_VNI, 12'h000, 24'h123456);
    issue_op(KIND_ADD, 12'h064, 24'hffffff);
    issue_op(KIND_LOOKUP_VLAN, 12'hfff, 24'h000000);
    issue_op(KIND_ADD, 12'h064, 24'h123456);
    issue_op(KIND_REM_VNI, 12'h000, 24'h123456);
    issue_op(KIND_REM_VLAN, 12'h064, 24'h000000);
    issue_op(KIND_ADD, 12'haaa, 24'h555555);
    issue_op(KIND_ADD, 12'h555, 24'haaaaaa);
    issue_op(KIND_SPARE_LO, 12'haaa, 24'h555555);
    issue_op(KIND_SPARE_HI, 12'hfff, 24'hffffff);
    issue_op(KIND_CLEAR, 12'h000, 24'h000000);
    issue_op(KIND_LOOKUP_VLAN, 12'haaa, 24'h000000);
    issue_op(KIND_REM_VNI, 12'h000, 24'haaaaaa);
    hold_until_drained();

    for (int n = 0; n < 115; n++) begin
      if (n == 60) hold_until_drained();
      if (n == 90) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 32) kind = KIND_ADD;
      else if (pick < 44) kind = KIND_REM_VLAN;
      else if (pick < 54) kind = KIND_REM_VNI;
      else if (pick < 72) kind = KIND_LOOKUP_VLAN;
      else if (pick < 92) kind = KIND_LOOKUP_VNI;
      else if (pick < 95) kind = KIND_CLEAR;
      else if (pick < 98) kind = KIND_SPARE_LO;
      else kind = KIND_SPARE_HI;
      issue_op(kind, pick_vlan(), pick_vni());
    end

    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (8200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
